// ===== src/bitmap_run_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap run allocator
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/bra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Field widths, request and status codes shared by the run allocator files.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int REQ_W  = 2;
	localparam int IDX_W  = 10;
	localparam int LEN_W  = 11;
	localparam int STAT_W = 2;
	// Wide enough for start_index + run_length without overflow.
	localparam int END_W  = 12;

	typedef enum logic [REQ_W-1:0] {
		REQ_SEARCH = 2'd0,
		REQ_SET    = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD       = 2'd2
	} status_t;

	// Operation handed to the word unit.
	typedef struct packed {
		logic search;
		logic set_bits;
	} op_t;

endpackage

// ===== src/bra_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_req_if
// Request channel: request type, start index and run length.
// ----------------------------------------------------------------------------
interface bra_req_if;
	import bra_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] start_index;
	logic [LEN_W-1:0] run_length;

	modport source (output valid, req_type, start_index, run_length, input ready);
	modport sink (input valid, req_type, start_index, run_length, output ready);

endinterface

// ===== src/bra_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_rsp_if
// Response channel: status and index of the run found.
// ----------------------------------------------------------------------------
interface bra_rsp_if;
	import bra_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  found_index;

	modport source (output valid, status, found_index, input ready);
	modport sink (input valid, status, found_index, output ready);

endinterface

// ===== src/bra_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bra_word_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_word_unit
// Processes one map word: finds the first free run that reaches the requested
// length, carrying the free count across words, and builds the updated word
// for set and clear requests.
// ----------------------------------------------------------------------------
module bra_word_unit #(
	parameter int WORD_BITS = 32,
	parameter int MAP_BITS = 1024,
	parameter int BASE_W = 11
) (
	input  bra_pkg::op_t              op,
	input  logic [WORD_BITS-1:0]      word,
	input  logic [BASE_W-1:0]         base,
	input  logic [BASE_W-1:0]         carry_in,
	input  logic [bra_pkg::IDX_W-1:0] start_index,
	input  logic [bra_pkg::END_W-1:0] end_pos,
	input  logic [bra_pkg::LEN_W-1:0] run_length,
	output logic                      hit,
	output logic [BASE_W-1:0]         found,
	output logic [BASE_W-1:0]         carry_out,
	output logic [WORD_BITS-1:0]      new_word
);
	import bra_pkg::*;

	localparam int CW = (BASE_W > END_W) ? BASE_W : END_W;

	always_comb begin : scan
		logic [CW-1:0]        pos;
		logic [CW-1:0]        run;
		logic [CW-1:0]        run_last;
		logic [WORD_BITS-1:0] mask;
		logic [WORD_BITS-1:0] hitv;

		run_last = '0;
		mask = '0;
		hitv = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			pos = CW'(base) + CW'(p);
			mask[p] = (pos >= CW'(start_index)) && (pos < CW'(end_pos));
			// Length of the free run ending at this bit; a reserved bit gives zero.
			run = CW'(carry_in) + CW'(p) + CW'(1);
			for (int q = 0; q < WORD_BITS; q++) begin
				if (q <= p && word[q]) begin
					run = CW'(p - q);
				end
			end
			hitv[p] = op.search && (run >= CW'(run_length)) && (pos < CW'(MAP_BITS));
			run_last = run;
		end

		hit = 1'b0;
		found = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (hitv[p]) begin
				hit = 1'b1;
				found = BASE_W'(CW'(base) + CW'(p) + CW'(1) - CW'(run_length));
			end
		end

		carry_out = BASE_W'(run_last);
		new_word = op.set_bits ? (word | mask) : (word & ~mask);
	end

endmodule

// ===== src/bitmap_run_allocator_unit.sv =====
`timescale 1ns / 1ps
// A request with a bad length, range or type skips the map and goes straight to S_DONE.
// Set and clear sweep every map word, one per cycle.
// A search stops at the word that completes the run.
// One request is in flight at a time; the word unit and single RAM read port set the pace.
// Reset clears control state at once, then a clearing pass writes zero to each of the
// WORD_COUNT map words (32 by default), one a cycle, with the request channel not ready.
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit
// First-fit allocator over a reservation bitmap held in RAM, one word a cycle.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit #(
	parameter int MAP_BITS = 1024,
	parameter int WORD_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	bra_req_if.sink  req,
	bra_rsp_if.source rsp
);
	import bra_pkg::*;

	localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int WCNT_W = $clog2(WORD_COUNT + 1);
	localparam int BASE_W = $clog2(WORD_COUNT * WORD_BITS + 1);
	localparam int LIM_W = ($clog2(MAP_BITS + 1) > END_W) ? $clog2(MAP_BITS + 1) : END_W;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t state_q;

	logic [WCNT_W-1:0]  rd_cnt_q;
	logic [BASE_W-1:0]  base_q;
	logic               vld_s1;
	logic               last_s1;
	logic [WADDR_W-1:0] idx_s1;
	logic [BASE_W-1:0]  base_s1;
	logic [BASE_W-1:0]  carry_q;

	op_t                op_q;
	logic [IDX_W-1:0]   start_q;
	logic [END_W-1:0]   end_q;
	logic [LEN_W-1:0]   len_q;

	logic [STAT_W-1:0]  res_status_q;
	logic [IDX_W-1:0]   res_found_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [IDX_W-1:0]   out_found_q;

	logic               accept;
	logic [LIM_W-1:0]   end_sum;
	logic               req_bad;
	logic               issue;
	logic               out_free;

	logic               ram_we;
	logic [WADDR_W-1:0] ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;

	logic               unit_hit;
	logic [BASE_W-1:0]  unit_found;
	logic [BASE_W-1:0]  unit_carry;
	logic [WORD_BITS-1:0] unit_word;

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign issue = (state_q == S_RUN) && (rd_cnt_q < WCNT_W'(WORD_COUNT));

	assign end_sum = LIM_W'(req.start_index) + LIM_W'(req.run_length);

	always_comb begin
		req_bad = 1'b1;
		if (req.run_length != '0) begin
			if (req.req_type == REQ_SEARCH) begin
				req_bad = LIM_W'(req.run_length) > LIM_W'(MAP_BITS);
			end else if (req.req_type == REQ_SET || req.req_type == REQ_CLEAR) begin
				req_bad = end_sum > LIM_W'(MAP_BITS);
			end
		end
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = rd_cnt_q[WADDR_W-1:0];
			ram_wdata = '0;
		end else begin
			ram_we = (state_q == S_RUN) && vld_s1 && !op_q.search;
			ram_waddr = idx_s1;
			ram_wdata = unit_word;
		end
	end

	bra_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_cnt_q[WADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	bra_word_unit #(
		.WORD_BITS (WORD_BITS),
		.MAP_BITS  (MAP_BITS),
		.BASE_W    (BASE_W)
	) u_unit (
		.op          (op_q),
		.word        (ram_rdata),
		.base        (base_s1),
		.carry_in    (carry_q),
		.start_index (start_q),
		.end_pos     (end_q),
		.run_length  (len_q),
		.hit         (unit_hit),
		.found       (unit_found),
		.carry_out   (unit_carry),
		.new_word    (unit_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rd_cnt_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					rd_cnt_q <= rd_cnt_q + WCNT_W'(1);
					if (rd_cnt_q == WCNT_W'(WORD_COUNT - 1)) begin
						rd_cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q.search <= (req.req_type == REQ_SEARCH);
						op_q.set_bits <= (req.req_type == REQ_SET);
						start_q <= req.start_index;
						end_q <= END_W'(end_sum);
						len_q <= req.run_length;
						rd_cnt_q <= '0;
						base_q <= '0;
						carry_q <= '0;
						if (req_bad) begin
							res_status_q <= ST_BAD;
							res_found_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + WCNT_W'(1);
						base_q <= base_q + BASE_W'(WORD_BITS);
						vld_s1 <= 1'b1;
						idx_s1 <= rd_cnt_q[WADDR_W-1:0];
						base_s1 <= base_q;
						last_s1 <= (rd_cnt_q == WCNT_W'(WORD_COUNT - 1));
					end
					if (vld_s1) begin
						carry_q <= unit_carry;
						if (op_q.search && unit_hit) begin
							// The run is complete: stop reading further words.
							res_status_q <= ST_OK;
							res_found_q <= IDX_W'(unit_found);
							vld_s1 <= 1'b0;
							state_q <= S_DONE;
						end else if (last_s1) begin
							res_status_q <= op_q.search ? ST_NOT_FOUND : ST_OK;
							res_found_q <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q <= res_found_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.found_index = out_found_q;

	`include "bitmap_run_allocator_unit_macros.svh"

	`BRA_ASSERT_SAME(a_ready_no_word_in_flight, req.ready, !vld_s1 && !ram_we,
		"request taken while a map word is still being processed")
	`BRA_ASSERT_NEXT(a_one_request_at_a_time, req.valid && req.ready, !req.ready,
		"second request taken before the first finished")
	`BRA_ASSERT_SAME(a_found_zero_on_failure, rsp.valid && (rsp.status != ST_OK),
		rsp.found_index == '0, "failed request reports a non-zero index")
	`BRA_ASSERT_SAME(a_write_only_when_updating, ram_we,
		(state_q == S_CLEAR) || ((state_q == S_RUN) && !op_q.search),
		"map written outside a clearing pass or an update")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap run allocator. A scripted opening covers
// the length and range limits, the unused request code and the word edges of
// the map. A long random mix of searches, sets and clears follows. Every
// answer is compared with its fixed script value or with a shadow copy of
// the reservation map, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import bra_pkg::*;

	localparam int MAP_BITS     = 1024;
	localparam int WORD_BITS    = 32;
	localparam int RANDOM_COUNT = 2000;
	localparam int STEADY_FIRST = 600;
	localparam int STEADY_LAST  = 900;
	localparam int HOLD_AT      = 1300;
	localparam int HOLD_CYCLES  = 400;
	localparam int PAUSE_AT     = 1600;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT   = 3000;
	localparam int SCRIPT_ROWS  = 25;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] found;
	} answer_t;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		logic             fixed;
		status_t          status;
		logic [IDX_W-1:0] found;
	} script_row_t;

	// Rows with fixed set carry their answer; the others are left to the shadow map.
	script_row_t script_rows [0:SCRIPT_ROWS-1] = '{
		'{REQ_SEARCH, 10'd0,    11'd1,    1'b1, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd1023, 11'd1024, 1'b1, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd0,    1'b1, ST_BAD,       10'd0},
		'{REQ_SEARCH, 10'd0,    11'd1025, 1'b1, ST_BAD,       10'd0},
		'{REQ_SEARCH, 10'd1023, 11'd2047, 1'b1, ST_BAD,       10'd0},
		'{REQ_SET,    10'd0,    11'd0,    1'b1, ST_BAD,       10'd0},
		'{REQ_SET,    10'd1023, 11'd2,    1'b1, ST_BAD,       10'd0},
		'{REQ_SET,    10'd1023, 11'd1,    1'b1, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd1024, 1'b1, ST_NOT_FOUND, 10'd0},
		'{REQ_SEARCH, 10'd0,    11'd1023, 1'b1, ST_OK,        10'd0},
		'{REQ_SET,    10'd0,    11'd1024, 1'b1, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd1,    1'b1, ST_NOT_FOUND, 10'd0},
		'{REQ_CLEAR,  10'd1023, 11'd1,    1'b1, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd1,    1'b1, ST_OK,        10'd1023},
		'{REQ_CLEAR,  10'd0,    11'd0,    1'b1, ST_BAD,       10'd0},
		'{REQ_UNUSED, 10'd5,    11'd5,    1'b1, ST_BAD,       10'd0},
		'{REQ_CLEAR,  10'd1000, 11'd100,  1'b1, ST_BAD,       10'd0},
		'{REQ_SET,    10'd1023, 11'd2047, 1'b1, ST_BAD,       10'd0},
		'{REQ_CLEAR,  10'd0,    11'd1024, 1'b1, ST_OK,        10'd0},
		'{REQ_SET,    10'd31,   11'd2,    1'b0, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd31,   1'b0, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd32,   1'b0, ST_OK,        10'd0},
		'{REQ_SET,    10'd512,  11'd512,  1'b0, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd512,  1'b0, ST_OK,        10'd0},
		'{REQ_SEARCH, 10'd0,    11'd513,  1'b0, ST_OK,        10'd0}
	};

	logic clk;
	logic arst_n;

	bra_req_if req_bus ();
	bra_rsp_if rsp_bus ();

	bitmap_run_allocator_unit #(
		.MAP_BITS (MAP_BITS),
		.WORD_BITS(WORD_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	logic [MAP_BITS-1:0] reserved_map;
	answer_t             pending_answers [$];

	int  requests_sent;
	int  searches_sent;
	int  sets_sent;
	int  clears_sent;
	int  unused_sent;
	int  ok_seen;
	int  not_found_seen;
	int  rejected_seen;
	int  error_count;
	bit  steady;
	bit  hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Updates the shadow map for one request and works out the answer it earns.
	function automatic void apply_request(input logic [REQ_W-1:0] kind,
			input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
			output answer_t ans);
		int first;
		int count;
		int run;
		first = int'(idx);
		run = int'(len);
		count = 0;
		ans.status = ST_BAD;
		ans.found = '0;
		if (kind == REQ_SEARCH) begin
			if (run != 0 && run <= MAP_BITS) begin
				ans.status = ST_NOT_FOUND;
				for (int b = 0; b < MAP_BITS; b++) begin
					if (reserved_map[b]) begin
						count = 0;
					end else begin
						count++;
						if (count >= run) begin
							ans.found = IDX_W'(b + 1 - run);
							ans.status = ST_OK;
							break;
						end
					end
				end
			end
		end else if (kind == REQ_SET || kind == REQ_CLEAR) begin
			if (run != 0 && first + run <= MAP_BITS) begin
				for (int b = 0; b < run; b++)
					reserved_map[first + b] = (kind == REQ_SET);
				ans.status = ST_OK;
			end
		end
	endfunction

	// Mostly well-formed traffic with short runs, some long ones and a little noise.
	function automatic void pick_random_request(output logic [REQ_W-1:0] kind,
			output logic [IDX_W-1:0] idx, output logic [LEN_W-1:0] len);
		int roll;
		int first;
		int room;
		roll = $urandom_range(0, 99);
		first = $urandom_range(0, MAP_BITS - 1);
		room = MAP_BITS - first;
		idx = IDX_W'(first);
		if (roll < 40) begin
			kind = REQ_SEARCH;
			if ($urandom_range(0, 9) == 0)
				len = LEN_W'($urandom_range(1, MAP_BITS));
			else
				len = LEN_W'($urandom_range(1, 64));
		end else if (roll < 92) begin
			kind = (roll < 66) ? REQ_SET : REQ_CLEAR;
			if (kind == REQ_CLEAR && $urandom_range(0, 39) == 0) begin
				idx = '0;
				len = LEN_W'(MAP_BITS);
			end else if ($urandom_range(0, 7) == 0) begin
				len = LEN_W'($urandom_range(1, room));
			end else begin
				len = LEN_W'($urandom_range(1, (room < 48) ? room : 48));
			end
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					kind = REQ_W'($urandom_range(0, 2));
					len = '0;
				end
				1: begin
					kind = REQ_UNUSED;
					len = LEN_W'($urandom_range(0, 2047));
				end
				2: begin
					kind = ($urandom_range(0, 1) == 0) ? REQ_SET : REQ_CLEAR;
					len = LEN_W'($urandom_range(room + 1, 2047));
				end
				default: begin
					kind = REQ_SEARCH;
					len = LEN_W'($urandom_range(MAP_BITS + 1, 2047));
				end
			endcase
		end
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic [LEN_W-1:0] len, input logic fixed, input answer_t fixed_answer);
		answer_t ans;
		while (!steady && $urandom_range(0, 99) < 33) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.start_index <= idx;
		req_bus.run_length <= len;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		apply_request(kind, idx, len, ans);
		if (fixed)
			ans = fixed_answer;
		pending_answers.push_back(ans);
		requests_sent++;
		case (kind)
			REQ_SEARCH: searches_sent++;
			REQ_SET:    sets_sent++;
			REQ_CLEAR:  clears_sent++;
			default:    unused_sent++;
		endcase
	endtask

	task automatic check_answer();
		answer_t ans;
		if (pending_answers.size() == 0) begin
			error_count++;
			$display("%0t: answer with nothing expected, got status %0d index %0d",
				$time, rsp_bus.status, rsp_bus.found_index);
		end else begin
			ans = pending_answers.pop_front();
			if (rsp_bus.status !== ans.status) begin
				error_count++;
				$display("%0t: status mismatch, expected %0d got %0d",
					$time, ans.status, rsp_bus.status);
			end
			if (rsp_bus.found_index !== ans.found) begin
				error_count++;
				$display("%0t: found_index mismatch, expected %0d got %0d",
					$time, ans.found, rsp_bus.found_index);
			end
			case (ans.status)
				ST_OK:        ok_seen++;
				ST_NOT_FOUND: not_found_seen++;
				default:      rejected_seen++;
			endcase
		end
	endtask

	// Answer side: checks each word taken and chooses ready for the next cycle.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready)
				check_answer();
			if (!hold_done && requests_sent >= RANDOM_COUNT / 2 + HOLD_AT - 1000) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (steady) begin
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= 33);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		logic [REQ_W-1:0] kind;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		answer_t          row_answer;
		reserved_map = '0;
		arst_n = 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= REQ_SEARCH;
		req_bus.start_index <= '0;
		req_bus.run_length <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			row_answer.status = script_rows[i].status;
			row_answer.found = script_rows[i].found;
			send_request(script_rows[i].kind, script_rows[i].idx, script_rows[i].len,
				script_rows[i].fixed, row_answer);
		end

		row_answer.status = ST_OK;
		row_answer.found = '0;
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			steady = (i >= STEADY_FIRST && i < STEADY_LAST);
			// Let the block drain completely once before carrying on.
			if (i == PAUSE_AT) begin
				req_bus.valid <= 1'b0;
				while (pending_answers.size() != 0)
					@(posedge clk);
			end
			pick_random_request(kind, idx, len);
			send_request(kind, idx, len, 1'b0, row_answer);
		end
		steady = 1'b0;
		req_bus.valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d searches, %0d sets, %0d clears, %0d unused codes.",
			requests_sent, searches_sent, sets_sent, clears_sent, unused_sent);
		$display("Answers: %0d ok, %0d no run found, %0d rejected; %0d mismatches.",
			ok_seen, not_found_seen, rejected_seen, error_count);
		if (error_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
